### hw/rtl/msps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package msps_pkg;

  // Field widths
  localparam int WIDTH_W = 15;
  localparam int STEP_W  = 20;
  localparam int TIME_W  = 16;
  localparam int CMP_W   = 16;
  localparam int MASK_W  = 32;
  localparam int GAP_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIDTH_W-1:0] RESET_WIDTH = 15'd1472;
  localparam logic [4:0]         DIV_LAST    = 5'd19;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_GAP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = 2'd1;

  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_REBUILD = 2'd2
  } msps_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_RD,
    ST_SET_CALC,
    ST_SET_DIV,
    ST_SET_WR,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_SCAN,
    ST_EMIT,
    ST_TERM
  } msps_state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         channel;
    logic [WIDTH_W-1:0] position;
    logic [TIME_W-1:0]  move_time;
  } msps_in_t;

  typedef struct packed {
    logic [CMP_W-1:0]  compare_value;
    logic [MASK_W-1:0] channel_mask;
    logic              last;
  } msps_out_t;

endpackage
`default_nettype wire

### hw/rtl/multi_servo_ramp_and_pulse_schedule_top.sv
// Servo ramp and pulse schedule.
// Input channel (in_valid / in_stall / in_data) takes one command transaction:
//   set target, tick ramp, or rebuild schedule. Output channel (out_valid /
//   out_stall / out_data) returns schedule entries after a rebuild: one per
//   merged run of widths in ascending order, then a terminator with last = 1.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready;
//   write only while the block is idle.
// Command steps, bounded by the single read port of each state memory:
//   set: read, setup, 20-step restoring divider, write; set with zero
//   move time: read, write; tick one channel: read, write; tick all: a
//   read and a write per channel; rebuild: a first pass for the minimum,
//   then a pass and an emit per run; each pass scans every channel once.
// A new command is taken once the previous one is finished; the terminator
//   sits in the output register while the next command is accepted.
// When out_stall is high the output register holds its entry and the rebuild
//   walk waits. Reset (synchronous, rst_n low) restores widths to 1472, steps
//   to zero and registers to their defaults through per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module multi_servo_ramp_and_pulse_schedule_top #(
  parameter int CHANNELS = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire msps_pkg::msps_in_t      in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output msps_pkg::msps_out_t          out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [msps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [msps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import msps_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [7:0]  CH_COUNT = 8'(CHANNELS);
  localparam logic [CW:0] CNT_END  = (CW+1)'(CHANNELS);
  localparam logic [CW:0] CNT_LAST = (CW+1)'(CHANNELS - 1);
  localparam logic [MASK_W-1:0] CH_MASK = MASK_W'((64'(1) << CHANNELS) - 64'(1));

  // State memories
  logic [WIDTH_W-1:0] cur_mem [CHANNELS];
  logic [WIDTH_W-1:0] tgt_mem [CHANNELS];
  logic [STEP_W-1:0]  stp_mem [CHANNELS];
  logic [CHANNELS-1:0] cur_vld_r, tgt_vld_r;

  logic [CW-1:0]      rd_addr, rd_addr_r;
  logic [WIDTH_W-1:0] rd_cur_r, rd_tgt_r;
  logic [STEP_W-1:0]  rd_stp_r;

  logic               cur_we, tgt_we;
  logic [CW-1:0]      wr_addr;
  logic [WIDTH_W-1:0] cur_wd, tgt_wd;
  logic [STEP_W-1:0]  stp_wd;

  // Control and datapath registers
  msps_state_t        state_r, state_nxt;
  logic [7:0]         ch_r, ch_nxt;
  logic [WIDTH_W-1:0] pos_r, pos_nxt;
  logic [TIME_W-1:0]  tm_r, tm_nxt;
  logic [CW:0]        cnt_r, cnt_nxt;
  logic               rvld_r, rvld_nxt;
  logic [WIDTH_W-1:0] first_r, first_nxt;
  logic               have_first_r, have_first_nxt;
  logic [WIDTH_W-1:0] min_r, min_nxt;
  logic               min_vld_r, min_vld_nxt;
  logic [MASK_W-1:0]  mask_r, mask_nxt;
  logic [MASK_W-1:0]  done_r, done_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [STEP_W-1:0]  quo_r, quo_nxt;
  logic [4:0]         dcnt_r, dcnt_nxt;
  logic [GAP_W-1:0]   gap_r;
  logic [CMP_W-1:0]   endm_r;
  logic               out_valid_r, out_valid_nxt;
  msps_out_t          out_data_r, out_data_nxt;

  logic               out_free;
  logic               in_acc;
  logic [WIDTH_W-1:0] set_diff;
  logic [16:0]        div_t;
  logic [16:0]        div_d;
  logic [MASK_W-1:0]  bit_sel;
  logic [WIDTH_W:0]   sum_up;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r  <= GAP_W'(5);
      endm_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MERGE_GAP) begin
        gap_r <= cfg_data[GAP_W-1:0];
      end else if (cfg_index == REG_END_MARKER) begin
        endm_r <= cfg_data;
      end
    end
  end

  // Memory write ports
  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[wr_addr] <= cur_wd;
    end
    if (tgt_we) begin
      tgt_mem[wr_addr] <= tgt_wd;
      stp_mem[wr_addr] <= stp_wd;
    end
  end

  // Entry valid bits; an unwritten entry reads as its reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= '0;
      tgt_vld_r <= '0;
    end else begin
      if (cur_we) cur_vld_r[wr_addr] <= 1'b1;
      if (tgt_we) tgt_vld_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr;
    rd_cur_r  <= cur_vld_r[rd_addr] ? cur_mem[rd_addr] : RESET_WIDTH;
    rd_tgt_r  <= tgt_vld_r[rd_addr] ? tgt_mem[rd_addr] : RESET_WIDTH;
    rd_stp_r  <= tgt_vld_r[rd_addr] ? stp_mem[rd_addr] : '0;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rvld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rvld_r      <= rvld_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ch_r         <= ch_nxt;
    pos_r        <= pos_nxt;
    tm_r         <= tm_nxt;
    cnt_r        <= cnt_nxt;
    first_r      <= first_nxt;
    have_first_r <= have_first_nxt;
    min_r        <= min_nxt;
    min_vld_r    <= min_vld_nxt;
    mask_r       <= mask_nxt;
    done_r       <= done_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    dcnt_r       <= dcnt_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Distance between target and current, restoring divider trial
  assign set_diff = (pos_r > rd_cur_r) ? (pos_r - rd_cur_r) : (rd_cur_r - pos_r);
  assign div_t    = {rem_r, quo_r[STEP_W-1]};
  assign div_d    = div_t - {1'b0, tm_r};
  assign bit_sel  = MASK_W'(1) << rd_addr_r;
  assign sum_up   = {1'b0, first_r} + (WIDTH_W+1)'(gap_r);

  // Next state and datapath
  always_comb begin
    logic [WIDTH_W-1:0] adv_dist;
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    pos_nxt        = pos_r;
    tm_nxt         = tm_r;
    cnt_nxt        = cnt_r;
    rvld_nxt       = 1'b0;
    first_nxt      = first_r;
    have_first_nxt = have_first_r;
    min_nxt        = min_r;
    min_vld_nxt    = min_vld_r;
    mask_nxt       = mask_r;
    done_nxt       = done_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dcnt_nxt       = dcnt_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    rd_addr        = ch_r[CW-1:0];
    wr_addr        = rd_addr_r;
    cur_we         = 1'b0;
    tgt_we         = 1'b0;
    cur_wd         = pos_r;
    tgt_wd         = pos_r;
    stp_wd         = '0;
    adv_dist       = (rd_tgt_r > rd_cur_r) ? (rd_tgt_r - rd_cur_r) : (rd_cur_r - rd_tgt_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ch_nxt  = in_data.channel;
          pos_nxt = in_data.position;
          tm_nxt  = in_data.move_time;
          cnt_nxt = '0;
          priority case (in_data.command)
            CMD_SET: begin
              if (in_data.channel < CH_COUNT) state_nxt = ST_SET_RD;
            end
            CMD_TICK: state_nxt = ST_TICK_RD;
            CMD_REBUILD: begin
              have_first_nxt = 1'b0;
              min_vld_nxt    = 1'b0;
              mask_nxt       = '0;
              done_nxt       = '0;
              state_nxt      = ST_SCAN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SET_RD: state_nxt = ST_SET_CALC;

      ST_SET_CALC: begin
        if (tm_r == '0) begin
          cur_we    = 1'b1;
          tgt_we    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          quo_nxt   = (STEP_W'(set_diff) << 4) + (STEP_W'(set_diff) << 2);
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = ST_SET_DIV;
        end
      end

      // One quotient bit a cycle
      ST_SET_DIV: begin
        if (div_t >= {1'b0, tm_r}) begin
          rem_nxt = div_d[15:0];
          quo_nxt = {quo_r[STEP_W-2:0], 1'b1};
        end else begin
          rem_nxt = div_t[15:0];
          quo_nxt = {quo_r[STEP_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == DIV_LAST) state_nxt = ST_SET_WR;
      end

      ST_SET_WR: begin
        tgt_we    = 1'b1;
        stp_wd    = quo_r + STEP_W'(1);
        state_nxt = ST_IDLE;
      end

      ST_TICK_RD: begin
        rd_addr   = (ch_r < CH_COUNT) ? ch_r[CW-1:0] : cnt_r[CW-1:0];
        state_nxt = ST_TICK_WR;
      end

      // Move one channel a step toward its target
      ST_TICK_WR: begin
        if (rd_cur_r != rd_tgt_r) begin
          cur_we = 1'b1;
          if (rd_stp_r == '0 || STEP_W'(adv_dist) < rd_stp_r) begin
            cur_wd = rd_tgt_r;
          end else if (rd_tgt_r > rd_cur_r) begin
            cur_wd = rd_cur_r + rd_stp_r[WIDTH_W-1:0];
          end else begin
            cur_wd = rd_cur_r - rd_stp_r[WIDTH_W-1:0];
          end
        end
        if (ch_r < CH_COUNT || cnt_r == CNT_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_TICK_RD;
        end
      end

      // One pass: collect the run of the current first width (once one is held), find next minimum
      ST_SCAN: begin
        rd_addr = cnt_r[CW-1:0];
        if (cnt_r < CNT_END) begin
          cnt_nxt  = cnt_r + 1'b1;
          rvld_nxt = 1'b1;
        end
        if (rvld_r && !done_r[rd_addr_r]) begin
          if (have_first_r && {1'b0, rd_cur_r} <= sum_up) begin
            mask_nxt = mask_r | bit_sel;
            done_nxt = done_r | bit_sel;
          end else if (!min_vld_r || rd_cur_r < min_r) begin
            min_nxt     = rd_cur_r;
            min_vld_nxt = 1'b1;
          end
        end
        if (cnt_r == CNT_END && !rvld_r) begin
          if (have_first_r) begin
            state_nxt = ST_EMIT;
          end else begin
            first_nxt      = min_r;
            have_first_nxt = 1'b1;
            min_vld_nxt    = 1'b0;
            mask_nxt       = '0;
            cnt_nxt        = '0;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.compare_value = CMP_W'(first_r);
          out_data_nxt.channel_mask  = mask_r;
          out_data_nxt.last          = 1'b0;
          if (min_vld_r) begin
            first_nxt   = min_r;
            min_vld_nxt = 1'b0;
            mask_nxt    = '0;
            cnt_nxt     = '0;
            state_nxt   = ST_SCAN;
          end else begin
            state_nxt = ST_TERM;
          end
        end
      end

      ST_TERM: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.compare_value = endm_r;
          out_data_nxt.channel_mask  = '0;
          out_data_nxt.last          = 1'b1;
          state_nxt                  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  // A rebuild transaction always leaves the input side busy next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.command == CMD_REBUILD) |=> in_stall)
    else $error("rebuild did not hold off input");

  // Terminator carries an empty mask and the end marker
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> (out_data.channel_mask == '0 &&
      out_data.compare_value == endm_r))
    else $error("bad terminator entry");

  // Only existing channels are ever marked as scheduled
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ((done_r & ~CH_MASK) == '0))
    else $error("schedule marked a channel out of range");
`endif

endmodule
`default_nettype wire
